[design/lut3d_pkg.sv]
package lut3d_pkg;

  // Table geometry
  localparam int GridBits   = 6;
  localparam int GridSize   = 1 << GridBits;
  localparam int GridMax    = GridSize - 1;
  localparam int FracBits   = 8 - GridBits;
  localparam int FracOne    = 1 << FracBits;
  localparam int TableBits  = 3 * GridBits;
  localparam int TableDepth = 1 << TableBits;
  localparam int EntryWidth = 24;

  // Blend arithmetic widths
  localparam int SumBits    = 3 * FracBits;
  localparam int WBits      = FracBits + 1;
  localparam int W2Bits     = 2 * FracBits + 1;
  localparam int W3Bits     = 3 * FracBits + 1;
  localparam int AccBits    = SumBits + 8;
  localparam int CornerBits = 3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdMap   = 1'b1;

  typedef logic [GridBits-1:0]   cell_t;
  typedef logic [WBits-1:0]      wgt_t;
  typedef logic [W2Bits-1:0]     wgt2_t;
  typedef logic [W3Bits-1:0]     wgt3_t;
  typedef logic [AccBits-1:0]    acc_t;
  typedef logic [TableBits-1:0]  addr_t;
  typedef logic [EntryWidth-1:0] entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic                  load;
    logic                  ram_we;
    logic                  issue;
    logic [CornerBits-1:0] corner;
    logic                  acc;
    logic                  out_load;
  } seq_ctl_t;

  // Drop the fraction bits, round to nearest with ties to even.
  function automatic logic [7:0] round_even(input acc_t total);
    acc_t q;
    acc_t rem;
    acc_t half;
    acc_t mask;
    mask = (AccBits'(1) << SumBits) - AccBits'(1);
    half = (AccBits'(1) << SumBits) >> 1;
    q    = total >> SumBits;
    rem  = total & mask;
    if ((SumBits > 0) && ((rem > half) || ((rem == half) && q[0]))) begin
      q = q + AccBits'(1);
    end
    return q[7:0];
  endfunction

endpackage

[design/lut3d_trilinear_color_map_top.sv]
// Trilinear 3-D color lookup table.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction.
// A write command (cmd_i = 0) stores {entry_c2, entry_c1, entry_c0} at
// entry_index_i in the 64x64x64 table and gives no result.
// A map command (cmd_i = 1) splits each pixel channel into cell and quarter
// fraction, reads the eight corner entries and blends them, rounding to
// nearest with ties to even. Every table entry must be written before mapping.
// Output channel (out_valid_o / out_stall_i) carries one mapped pixel per map.
// A map holds the input stalled from acceptance until its result is loaded: eight
// corner reads through the single port of the table memory, one per cycle, then
// a drain of the last read and a rounding step into the output register.
// So writes sustain one per cycle while no map is in progress, and the block
// takes no new command until a map has loaded its result.
// When the receiver stalls, the result holds in the output register and the
// block still takes writes and starts the next map; that map then waits with
// its finished sums until the output register frees up.
// Reset clears the sequencer and the output valid; table contents are not
// cleared and stay undefined until written.
module lut3d_trilinear_color_map_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [17:0]                    entry_index_i,
  input  logic [7:0]                     entry_c0_i,
  input  logic [7:0]                     entry_c1_i,
  input  logic [7:0]                     entry_c2_i,
  input  logic [7:0]                     pixel_c0_i,
  input  logic [7:0]                     pixel_c1_i,
  input  logic [7:0]                     pixel_c2_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_c0_o,
  output logic [7:0]                     out_c1_o,
  output logic [7:0]                     out_c2_o
);

  lut3d_pkg::seq_ctl_t ctl;
  lut3d_pkg::addr_t    corner_addr;
  lut3d_pkg::addr_t    ram_addr;
  lut3d_pkg::entry_t   ram_rdata;

  lut3d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  lut3d_blend u_blend (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .pixel_c0_i    (pixel_c0_i),
    .pixel_c1_i    (pixel_c1_i),
    .pixel_c2_i    (pixel_c2_i),
    .rdata_i       (ram_rdata),
    .corner_addr_o (corner_addr),
    .out_c0_o      (out_c0_o),
    .out_c1_o      (out_c1_o),
    .out_c2_o      (out_c2_o)
  );

  // The sequencer owns the port during a map; otherwise it serves writes.
  assign ram_addr = ctl.issue ? corner_addr
                              : entry_index_i[lut3d_pkg::TableBits-1:0];

  lut3d_ram #(
    .Width (lut3d_pkg::EntryWidth),
    .Depth (lut3d_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ctl.ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({entry_c2_i, entry_c1_i, entry_c0_i}),
    .rdata_o (ram_rdata)
  );

endmodule

[design/lut3d_ram.sv]
module lut3d_ram #(
  parameter int Width = 24,
  parameter int Depth = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lut3d_ctrl.sv]
module lut3d_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lut3d_pkg::seq_ctl_t ctl_o
);

  lut3d_pkg::seq_state_e state_q, state_d;
  logic [lut3d_pkg::CornerBits-1:0] cnt_q, cnt_d;
  logic acc_q, acc_d;
  logic out_valid_q, out_valid_d;
  logic in_accept;
  logic out_free;

  assign in_stall_o = (state_q != lut3d_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lut3d_pkg::S_IDLE: begin
        if (in_accept && (cmd_i == lut3d_pkg::CmdMap)) begin
          state_d = lut3d_pkg::S_RUN;
        end
      end
      lut3d_pkg::S_RUN: begin
        if (cnt_q == {lut3d_pkg::CornerBits{1'b1}}) begin
          state_d = lut3d_pkg::S_FLUSH;
        end
      end
      lut3d_pkg::S_FLUSH: begin
        state_d = lut3d_pkg::S_DONE;
      end
      lut3d_pkg::S_DONE: begin
        if (out_free) begin
          state_d = lut3d_pkg::S_IDLE;
        end
      end
      default: state_d = lut3d_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.load     = in_accept && (cmd_i == lut3d_pkg::CmdMap);
    ctl_o.ram_we   = in_accept && (cmd_i == lut3d_pkg::CmdWrite);
    ctl_o.issue    = (state_q == lut3d_pkg::S_RUN);
    ctl_o.corner   = cnt_q;
    ctl_o.acc      = acc_q;
    ctl_o.out_load = (state_q == lut3d_pkg::S_DONE) && out_free;
  end

  // Read data arrives in the cycle after its address is issued.
  assign cnt_d       = ctl_o.issue ? cnt_q + 1'b1 : '0;
  assign acc_d       = ctl_o.issue;
  assign out_valid_d = ctl_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lut3d_pkg::S_IDLE;
      cnt_q       <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/lut3d_blend.sv]
module lut3d_blend (
  input  logic                clk_i,
  input  lut3d_pkg::seq_ctl_t ctl_i,
  input  logic [7:0]          pixel_c0_i,
  input  logic [7:0]          pixel_c1_i,
  input  logic [7:0]          pixel_c2_i,
  input  lut3d_pkg::entry_t   rdata_i,
  output lut3d_pkg::addr_t    corner_addr_o,
  output logic [7:0]          out_c0_o,
  output logic [7:0]          out_c1_o,
  output logic [7:0]          out_c2_o
);

  logic [7:0]          px [3];
  lut3d_pkg::cell_t    cell_d [3];
  lut3d_pkg::cell_t    cell_q [3];
  lut3d_pkg::wgt_t     frac [3];
  lut3d_pkg::wgt_t     w_lo [3];
  lut3d_pkg::wgt_t     w_hi [3];
  lut3d_pkg::wgt2_t    w01_d [4];
  lut3d_pkg::wgt2_t    w01_q [4];
  lut3d_pkg::wgt_t     w2_q [2];
  lut3d_pkg::wgt3_t    wt_q;
  lut3d_pkg::acc_t     sum_q [3];
  logic [7:0]          out_q [3];
  lut3d_pkg::cell_t    a0, a1, a2;

  assign px[0] = pixel_c0_i;
  assign px[1] = pixel_c1_i;
  assign px[2] = pixel_c2_i;

  // Split each channel into grid cell and fraction; clamp the top cell.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cell_d[i] = lut3d_pkg::GridBits'(px[i] >> lut3d_pkg::FracBits);
      frac[i]   = lut3d_pkg::WBits'(px[i] & 8'(lut3d_pkg::FracOne - 1));
      if (cell_d[i] == lut3d_pkg::cell_t'(lut3d_pkg::GridMax)) begin
        frac[i] = '0;
      end
      w_lo[i] = lut3d_pkg::WBits'(lut3d_pkg::FracOne) - frac[i];
      w_hi[i] = frac[i];
    end
  end

  // Partial weights over axes 0 and 1, index {b0, b1}.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      w01_d[k] = lut3d_pkg::W2Bits'(
                   lut3d_pkg::W2Bits'(k[1] ? w_hi[0] : w_lo[0]) *
                   lut3d_pkg::W2Bits'(k[0] ? w_hi[1] : w_lo[1]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < 3; i++) begin
        cell_q[i] <= cell_d[i];
      end
      for (int k = 0; k < 4; k++) begin
        w01_q[k] <= w01_d[k];
      end
      w2_q[0] <= w_lo[2];
      w2_q[1] <= w_hi[2];
    end
  end

  // Corner bits: b0 = corner[2], b1 = corner[1], b2 = corner[0].
  assign a0 = cell_q[0] + lut3d_pkg::cell_t'(ctl_i.corner[2]);
  assign a1 = cell_q[1] + lut3d_pkg::cell_t'(ctl_i.corner[1]);
  assign a2 = cell_q[2] + lut3d_pkg::cell_t'(ctl_i.corner[0]);
  assign corner_addr_o = {a2, a0, a1};

  // Align the corner weight with the read data.
  always_ff @(posedge clk_i) begin
    wt_q <= lut3d_pkg::W3Bits'(
              lut3d_pkg::W3Bits'(w01_q[ctl_i.corner[2:1]]) *
              lut3d_pkg::W3Bits'(w2_q[ctl_i.corner[0]]));
  end

  // Skip zero-weight corners: they may wrap past the table edge or be unwritten.
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (ctl_i.load) begin
        sum_q[ch] <= '0;
      end else if (ctl_i.acc && (wt_q != '0)) begin
        sum_q[ch] <= sum_q[ch] + lut3d_pkg::AccBits'(
                       lut3d_pkg::AccBits'(wt_q) *
                       lut3d_pkg::AccBits'(rdata_i[8*ch +: 8]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_q[ch] <= lut3d_pkg::round_even(sum_q[ch]);
      end
    end
  end

  assign out_c0_o = out_q[0];
  assign out_c1_o = out_q[1];
  assign out_c2_o = out_q[2];

endmodule

[bench/lut3d_trilinear_color_map_top_tb.sv]
`timescale 1ns / 100ps

module lut3d_trilinear_color_map_top_tb;

  localparam int RandomItems = 1050;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 24;

  typedef struct packed {
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } rgb_t;

  typedef struct packed {
    logic        cmd;
    logic [17:0] index;
    rgb_t        entry;
    rgb_t        pixel;
  } lut_cmd_t;

  typedef struct packed {
    lut_cmd_t cmd;
    logic     has_want;
    rgb_t     want;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        cmd_i         = lut3d_pkg::CmdWrite;
  logic [17:0] entry_index_i = '0;
  logic [7:0]  entry_c0_i    = '0;
  logic [7:0]  entry_c1_i    = '0;
  logic [7:0]  entry_c2_i    = '0;
  logic [7:0]  pixel_c0_i    = '0;
  logic [7:0]  pixel_c1_i    = '0;
  logic [7:0]  pixel_c2_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  out_c0_o;
  logic [7:0]  out_c1_o;
  logic [7:0]  out_c2_o;

  lut3d_pkg::entry_t lut_image [lut3d_pkg::TableDepth];
  bit                lut_written [lut3d_pkg::TableDepth];
  rgb_t              pending_pixels [$];
  dir_row_t          dir_rows [$];
  int                mismatch_count = 0;
  int                cycle_count    = 0;
  int                sent_count     = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;

  lut3d_trilinear_color_map_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_c0_i    (entry_c0_i),
    .entry_c1_i    (entry_c1_i),
    .entry_c2_i    (entry_c2_i),
    .pixel_c0_i    (pixel_c0_i),
    .pixel_c1_i    (pixel_c1_i),
    .pixel_c2_i    (pixel_c2_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_c0_o      (out_c0_o),
    .out_c1_o      (out_c1_o),
    .out_c2_o      (out_c2_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ERROR %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic lut3d_pkg::addr_t corner_addr(input int a0, input int a1, input int a2);
    return lut3d_pkg::addr_t'((a2 * lut3d_pkg::GridSize + a0) * lut3d_pkg::GridSize + a1);
  endfunction

  // Trilinear blend of the eight corners around a pixel, rounded half to even.
  function automatic rgb_t blend_pixel(input rgb_t px);
    int                grid_pos [3];
    int                frac [3];
    int                sum [3];
    logic [7:0]        lvl [3];
    int                wt;
    int                q;
    int                rem;
    lut3d_pkg::entry_t e;
    lvl[0] = px.c0;
    lvl[1] = px.c1;
    lvl[2] = px.c2;
    for (int k = 0; k < 3; k++) begin
      grid_pos[k] = int'(lvl[k]) >> lut3d_pkg::FracBits;
      frac[k]     = int'(lvl[k]) & (lut3d_pkg::FracOne - 1);
      if (grid_pos[k] >= lut3d_pkg::GridMax) begin
        grid_pos[k] = lut3d_pkg::GridMax;
        frac[k]     = 0;
      end
      sum[k] = 0;
    end
    for (int b = 0; b < 8; b++) begin
      wt = 1;
      for (int k = 0; k < 3; k++) begin
        wt = wt * ((((b >> k) & 1) == 1) ? frac[k] : lut3d_pkg::FracOne - frac[k]);
      end
      if (wt != 0) begin
        e = lut_image[corner_addr(grid_pos[0] + (b & 1), grid_pos[1] + ((b >> 1) & 1),
                                  grid_pos[2] + ((b >> 2) & 1))];
        for (int k = 0; k < 3; k++) begin
          sum[k] += wt * int'(e[8*k +: 8]);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      q   = sum[k] >> lut3d_pkg::SumBits;
      rem = sum[k] & ((1 << lut3d_pkg::SumBits) - 1);
      if ((rem > (1 << (lut3d_pkg::SumBits - 1))) ||
          ((rem == (1 << (lut3d_pkg::SumBits - 1))) && q[0])) begin
        q++;
      end
      lvl[k] = q[7:0];
    end
    return {lvl[2], lvl[1], lvl[0]};
  endfunction

  // Drive one transaction from a falling edge; return at the falling edge after acceptance.
  task automatic send_cmd(input lut_cmd_t c, input logic has_want, input rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c.cmd;
    entry_index_i <= c.index;
    entry_c0_i    <= c.entry.c0;
    entry_c1_i    <= c.entry.c1;
    entry_c2_i    <= c.entry.c2;
    pixel_c0_i    <= c.pixel.c0;
    pixel_c1_i    <= c.pixel.c1;
    pixel_c2_i    <= c.pixel.c2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    if (c.cmd == lut3d_pkg::CmdWrite) begin
      lut_image[lut3d_pkg::addr_t'(c.index)]   = c.entry;
      lut_written[lut3d_pkg::addr_t'(c.index)] = 1'b1;
    end else begin
      pending_pixels.push_back(has_want ? want : blend_pixel(c.pixel));
    end
    @(negedge clk_i);
  endtask

  // Write random content into any corner of the pixel's cell not yet written.
  task automatic prime_corners(input rgb_t px);
    int                 grid_pos [3];
    lut3d_pkg::addr_t   a;
    lut_cmd_t           w;
    grid_pos[0] = int'(px.c0) >> lut3d_pkg::FracBits;
    grid_pos[1] = int'(px.c1) >> lut3d_pkg::FracBits;
    grid_pos[2] = int'(px.c2) >> lut3d_pkg::FracBits;
    for (int b = 0; b < 8; b++) begin
      a = corner_addr((grid_pos[0] + (b & 1)) > lut3d_pkg::GridMax ? lut3d_pkg::GridMax
                                                : grid_pos[0] + (b & 1),
                      (grid_pos[1] + ((b >> 1) & 1)) > lut3d_pkg::GridMax ? lut3d_pkg::GridMax
                                                : grid_pos[1] + ((b >> 1) & 1),
                      (grid_pos[2] + ((b >> 2) & 1)) > lut3d_pkg::GridMax ? lut3d_pkg::GridMax
                                                : grid_pos[2] + ((b >> 2) & 1));
      if (!lut_written[a]) begin
        w.cmd   = lut3d_pkg::CmdWrite;
        w.index = a;
        w.entry = 24'($urandom);
        w.pixel = 24'($urandom);
        send_cmd(w, 1'b0, '0);
      end
    end
  endtask

  function automatic dir_row_t wr_row(input int idx, input int c0, input int c1, input int c2);
    dir_row_t r;
    r.cmd.cmd   = lut3d_pkg::CmdWrite;
    r.cmd.index = 18'(idx);
    r.cmd.entry = {8'(c2), 8'(c1), 8'(c0)};
    r.cmd.pixel = 24'($urandom);
    r.has_want  = 1'b0;
    r.want      = '0;
    return r;
  endfunction

  function automatic dir_row_t mp_row(input int p0, input int p1, input int p2,
                                      input logic has_want, input int w0, input int w1,
                                      input int w2);
    dir_row_t r;
    r.cmd.cmd   = lut3d_pkg::CmdMap;
    r.cmd.index = 18'($urandom);
    r.cmd.entry = 24'($urandom);
    r.cmd.pixel = {8'(p2), 8'(p1), 8'(p0)};
    r.has_want  = has_want;
    r.want      = {8'(w2), 8'(w1), 8'(w0)};
    return r;
  endfunction

  function automatic logic [7:0] pick_level(input int unsigned mode, input int base);
    int v;
    case (mode)
      0: begin
        v = base * lut3d_pkg::FracOne + int'($urandom_range(11));
        return (v > 255) ? 8'hFF : 8'(v);
      end
      1: begin
        case ($urandom_range(3))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'($urandom_range(255, 252));
          default: return 8'($urandom_range(63) * lut3d_pkg::FracOne);
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("mapped pixel with none pending", {out_c2_o, out_c1_o, out_c0_o}, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_c0_o !== want.c0) report_mismatch("out_c0", out_c0_o, want.c0);
        if (out_c1_o !== want.c1) report_mismatch("out_c1", out_c1_o, want.c1);
        if (out_c2_o !== want.c2) report_mismatch("out_c2", out_c2_o, want.c2);
      end
    end
  end

  initial begin
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    int          start;
    int          base;
    int unsigned mode;
    lut_cmd_t    c;
    send_pct = '{35, 62, 0};
    recv_pct = '{62, 35, 0};

    // Directed rows; hand-typed results only where a single entry is read.
    dir_rows.push_back(wr_row(0, 'h00, 'hFF, 'h80));
    dir_rows.push_back(mp_row(0, 0, 0, 1'b1, 'h00, 'hFF, 'h80));
    dir_rows.push_back(wr_row(lut3d_pkg::TableDepth - 1, 'hFF, 'h00, 'h5A));
    dir_rows.push_back(mp_row(255, 255, 255, 1'b1, 'hFF, 'h00, 'h5A));
    dir_rows.push_back(mp_row(252, 253, 254, 1'b1, 'hFF, 'h00, 'h5A));
    dir_rows.push_back(wr_row(64, 'h40, 'h80, 'hC1));
    dir_rows.push_back(mp_row(4, 0, 0, 1'b1, 'h40, 'h80, 'hC1));
    // halfway between two entries: ties round both up and down to even
    dir_rows.push_back(mp_row(2, 0, 0, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(1, 0, 0, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(3, 0, 0, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(0, 2, 0, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(0, 0, 2, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(1, 2, 3, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(3, 3, 3, 1'b0, 0, 0, 0));
    dir_rows.push_back(wr_row(lut3d_pkg::TableDepth - 1, 'h00, 'hFF, 'h00));
    dir_rows.push_back(mp_row(255, 255, 255, 1'b1, 'h00, 'hFF, 'h00));
    dir_rows.push_back(mp_row(251, 251, 251, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(255, 0, 255, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(0, 255, 128, 1'b0, 0, 0, 0));
    dir_rows.push_back(mp_row(129, 66, 200, 1'b0, 0, 0, 0));
    dir_rows.push_back(wr_row(lut3d_pkg::TableDepth / 2, 'h12, 'h34, 'h56));
    dir_rows.push_back(mp_row(0, 0, 128, 1'b1, 'h12, 'h34, 'h56));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cmd.cmd == lut3d_pkg::CmdMap) prime_corners(dir_rows[i].cmd.pixel);
      send_cmd(dir_rows[i].cmd, dir_rows[i].has_want, dir_rows[i].want);
    end

    start = sent_count;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      base = $urandom_range(61);
      while (sent_count - start < RandomItems * (ph + 1) / 3) begin
        if ($urandom_range(39) == 0) base = $urandom_range(61);
        c.index = 18'($urandom);
        c.entry = 24'($urandom);
        c.pixel = 24'($urandom);
        if ($urandom_range(99) < 25) begin
          c.cmd = lut3d_pkg::CmdWrite;
        end else begin
          // in half of the maps, a local region so written corners get reused
          c.cmd = lut3d_pkg::CmdMap;
          case ($urandom_range(19)) inside
            [0:9]:   mode = 0;
            [10:13]: mode = 1;
            default: mode = 2;
          endcase
          c.pixel.c0 = pick_level(mode, base);
          c.pixel.c1 = pick_level(mode, base);
          c.pixel.c2 = pick_level(mode, base);
          prime_corners(c.pixel);
        end
        send_cmd(c, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
